// ===== sv/fce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_pkg
// shared types, codes and constants of the chain engine
// ----------------------------------------------------------------------------
package fce_pkg;

  localparam int TABLE_ENTRIES_DEF = 8192;
  localparam int IDX_BITS = 16;
  localparam int CFG_BITS = 14;
  localparam int HOP_BITS = 13;
  localparam int REQ_BITS = 3;
  localparam int STS_BITS = 2;

  localparam logic [IDX_BITS-1:0] END_OF_CHAIN = 16'hFFFF;
  localparam logic [IDX_BITS-1:0] FREE_ENTRY = 16'h0000;
  localparam logic [CFG_BITS-1:0] DBC_RESET = 14'd8192;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_LOAD   = 3'd0,
    REQ_READ   = 3'd1,
    REQ_WALK   = 3'd2,
    REQ_FREE   = 3'd3,
    REQ_APPEND = 3'd4,
    REQ_COUNT  = 3'd5
  } req_code_t;

  typedef enum logic [STS_BITS-1:0] {
    STS_OK        = 2'd0,
    STS_NO_FREE   = 2'd1,
    STS_RANGE     = 2'd2,
    STS_CHAIN_END = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_READ_WAIT,
    ST_WALK_CHK,
    ST_WALK_WAIT,
    ST_FREE_CHK,
    ST_FREE_WAIT,
    ST_SCAN,
    ST_APPEND_TAIL,
    ST_APPEND_NEW,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    MEM_NONE,
    MEM_RD_CUR,
    MEM_WR_LOAD,
    MEM_WR_ZERO,
    MEM_WR_TAIL,
    MEM_WR_EOC
  } mem_op_t;

  typedef enum logic [2:0] {
    SEL_ZERO,
    SEL_CUR,
    SEL_EOC,
    SEL_FOUND,
    SEL_READ,
    SEL_COUNT
  } res_sel_t;

  typedef struct packed {
    logic     accept;
    mem_op_t  mem_op;
    logic     advance;
    logic     scan_run;
    logic     found_ld;
    logic     res_we;
    status_t  res_status;
    res_sel_t res_sel;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [REQ_BITS-1:0] op;
    logic                in_range;
    logic                cur_eoc;
    logic                cur_ge_n;
    logic                hops_zero;
    logic                iter_eq_n;
    logic                scan_hit;
    logic                scan_done;
  } dp_sts_t;

endpackage

// ===== sv/fce_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_req_if
// request channel: valid/ready handshake with one request word
// ----------------------------------------------------------------------------
interface fce_req_if;
  logic                          valid;
  logic                          ready;
  logic [fce_pkg::REQ_BITS-1:0]  req_type;
  logic [fce_pkg::IDX_BITS-1:0]  block_index;
  logic [fce_pkg::IDX_BITS-1:0]  entry_value;
  logic [fce_pkg::HOP_BITS-1:0]  hop_count;

  modport source (output valid, req_type, block_index, entry_value, hop_count,
                  input ready);
  modport sink (input valid, req_type, block_index, entry_value, hop_count,
                output ready);
endinterface

// ===== sv/fce_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_rsp_if
// response channel: valid/ready handshake with one result word
// ----------------------------------------------------------------------------
interface fce_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [fce_pkg::STS_BITS-1:0]  status;
  logic [fce_pkg::IDX_BITS-1:0]  result_index;
  logic [fce_pkg::IDX_BITS-1:0]  read_value;
  logic [fce_pkg::CFG_BITS-1:0]  free_count;

  modport source (output valid, status, result_index, read_value, free_count,
                  input ready);
  modport sink (input valid, status, result_index, read_value, free_count,
                output ready);
endinterface

// ===== sv/fce_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_datapath
// table memory, request registers, scan pipeline and result registers
// ----------------------------------------------------------------------------
module fce_datapath #(
  parameter int TABLE_ENTRIES = fce_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [fce_pkg::CFG_BITS-1:0]  cfg_wr_data,
  input  logic [fce_pkg::REQ_BITS-1:0]  in_req_type,
  input  logic [fce_pkg::IDX_BITS-1:0]  in_block_index,
  input  logic [fce_pkg::IDX_BITS-1:0]  in_entry_value,
  input  logic [fce_pkg::HOP_BITS-1:0]  in_hop_count,
  input  fce_pkg::dp_cmd_t              cmd,
  output fce_pkg::dp_sts_t              sts,
  output logic [fce_pkg::STS_BITS-1:0]  out_status,
  output logic [fce_pkg::IDX_BITS-1:0]  out_result_index,
  output logic [fce_pkg::IDX_BITS-1:0]  out_read_value,
  output logic [fce_pkg::CFG_BITS-1:0]  out_free_count
);

  localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int IW = fce_pkg::IDX_BITS;
  localparam logic [IW-1:0] TABLE_LIMIT = IW'(TABLE_ENTRIES);

  logic [IW-1:0] table_mem [TABLE_ENTRIES];
  logic [IW-1:0] rd_data;

  logic [fce_pkg::CFG_BITS-1:0] dbc;
  logic [fce_pkg::REQ_BITS-1:0] op;
  logic [IW-1:0]                cur;
  logic [IW-1:0]                val;
  logic [fce_pkg::HOP_BITS-1:0] hops;
  logic [IW-1:0]                iter;
  logic [IW-1:0]                ptr;
  logic                         pend;
  logic [IW-1:0]                pend_addr;
  logic [fce_pkg::CFG_BITS-1:0] cnt;
  logic [IW-1:0]                found;

  fce_pkg::status_t             res_status;
  logic [IW-1:0]                res_index;
  logic [IW-1:0]                res_read;
  logic [fce_pkg::CFG_BITS-1:0] res_count;
  logic [IW-1:0]                res_index_next;
  logic [IW-1:0]                res_read_next;
  logic [fce_pkg::CFG_BITS-1:0] res_count_next;

  logic [IW-1:0]     dbc_ext;
  logic [IW-1:0]     n;
  logic              ptr_lt_n;
  logic              mem_we;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_wa;
  logic [ADDR_W-1:0] mem_ra;
  logic [IW-1:0]     mem_wd;

  // active limit: min of configured count and table size
  assign dbc_ext  = IW'(dbc);
  assign n        = (dbc_ext > TABLE_LIMIT) ? TABLE_LIMIT : dbc_ext;
  assign ptr_lt_n = ptr < n;

  always_comb begin
    sts.op        = op;
    sts.in_range  = cur < TABLE_LIMIT;
    sts.cur_eoc   = cur == fce_pkg::END_OF_CHAIN;
    sts.cur_ge_n  = cur >= n;
    sts.hops_zero = hops == '0;
    sts.iter_eq_n = iter == n;
    sts.scan_hit  = pend && (rd_data == fce_pkg::FREE_ENTRY);
    sts.scan_done = !pend && !ptr_lt_n;
  end

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = cur[ADDR_W-1:0];
    mem_ra = cur[ADDR_W-1:0];
    mem_wd = val;
    case (cmd.mem_op)
      fce_pkg::MEM_RD_CUR:  mem_re = 1'b1;
      fce_pkg::MEM_WR_LOAD: mem_we = 1'b1;
      fce_pkg::MEM_WR_ZERO: begin
        mem_we = 1'b1;
        mem_wd = fce_pkg::FREE_ENTRY;
      end
      fce_pkg::MEM_WR_TAIL: begin
        mem_we = 1'b1;
        mem_wd = found;
      end
      fce_pkg::MEM_WR_EOC: begin
        mem_we = 1'b1;
        mem_wa = found[ADDR_W-1:0];
        mem_wd = fce_pkg::END_OF_CHAIN;
      end
      default: ;
    endcase
    if (cmd.scan_run && ptr_lt_n) begin
      mem_re = 1'b1;
      mem_ra = ptr[ADDR_W-1:0];
    end
  end

  // single write port, registered read port
  always_ff @(posedge clk) begin
    if (mem_we) table_mem[mem_wa] <= mem_wd;
    if (mem_re) rd_data <= table_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dbc <= fce_pkg::DBC_RESET;
    end else if (cfg_wr_en) begin
      dbc <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (cmd.accept) begin
      pend <= 1'b0;
    end else if (cmd.scan_run) begin
      pend <= ptr_lt_n;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op   <= in_req_type;
      cur  <= in_block_index;
      val  <= in_entry_value;
      hops <= in_hop_count;
      iter <= '0;
      cnt  <= '0;
      ptr  <= (in_req_type == fce_pkg::REQ_APPEND) ? IW'(1) : '0;
    end else begin
      if (cmd.advance) begin
        cur  <= rd_data;
        hops <= hops - 1'b1;
        iter <= iter + 1'b1;
      end
      if (cmd.scan_run) begin
        if (ptr_lt_n) begin
          ptr       <= ptr + 1'b1;
          pend_addr <= ptr;
        end
        if (sts.scan_hit) cnt <= cnt + 1'b1;
      end
    end
    if (cmd.found_ld) found <= pend_addr;
  end

  // fields not picked by the result select stay zero
  always_comb begin
    res_index_next = '0;
    res_read_next  = '0;
    res_count_next = '0;
    case (cmd.res_sel)
      fce_pkg::SEL_CUR:   res_index_next = cur;
      fce_pkg::SEL_EOC:   res_index_next = fce_pkg::END_OF_CHAIN;
      fce_pkg::SEL_FOUND: res_index_next = found;
      fce_pkg::SEL_READ:  res_read_next  = rd_data;
      fce_pkg::SEL_COUNT: res_count_next = cnt;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      res_index  <= res_index_next;
      res_read   <= res_read_next;
      res_count  <= res_count_next;
    end
    if (cmd.out_load) begin
      out_status       <= res_status;
      out_result_index <= res_index;
      out_read_value   <= res_read;
      out_free_count   <= res_count;
    end
  end

endmodule

// ===== sv/fce_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fce_ctrl
// request sequencer: decodes a request and steps the datapath through it
// ----------------------------------------------------------------------------
module fce_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  fce_pkg::dp_sts_t sts,
  output fce_pkg::dp_cmd_t cmd
);

  fce_pkg::state_t state;
  fce_pkg::state_t state_next;
  logic            out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= fce_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      fce_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = fce_pkg::ST_DECODE;
        end
      end
      fce_pkg::ST_DECODE: begin
        case (sts.op)
          fce_pkg::REQ_LOAD: begin
            cmd.res_we  = 1'b1;
            cmd.res_sel = fce_pkg::SEL_ZERO;
            if (sts.in_range) begin
              cmd.mem_op     = fce_pkg::MEM_WR_LOAD;
              cmd.res_status = fce_pkg::STS_OK;
            end else begin
              cmd.res_status = fce_pkg::STS_RANGE;
            end
            state_next = fce_pkg::ST_DONE;
          end
          fce_pkg::REQ_READ: begin
            if (sts.in_range) begin
              cmd.mem_op = fce_pkg::MEM_RD_CUR;
              state_next = fce_pkg::ST_READ_WAIT;
            end else begin
              cmd.res_we     = 1'b1;
              cmd.res_status = fce_pkg::STS_RANGE;
              cmd.res_sel    = fce_pkg::SEL_ZERO;
              state_next     = fce_pkg::ST_DONE;
            end
          end
          fce_pkg::REQ_WALK: state_next = fce_pkg::ST_WALK_CHK;
          fce_pkg::REQ_FREE: state_next = fce_pkg::ST_FREE_CHK;
          fce_pkg::REQ_APPEND: begin
            if (!sts.cur_eoc && sts.cur_ge_n) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = fce_pkg::STS_RANGE;
              cmd.res_sel    = fce_pkg::SEL_EOC;
              state_next     = fce_pkg::ST_DONE;
            end else begin
              state_next = fce_pkg::ST_SCAN;
            end
          end
          fce_pkg::REQ_COUNT: state_next = fce_pkg::ST_SCAN;
          default: begin
            cmd.res_we     = 1'b1;
            cmd.res_status = fce_pkg::STS_OK;
            cmd.res_sel    = fce_pkg::SEL_ZERO;
            state_next     = fce_pkg::ST_DONE;
          end
        endcase
      end
      fce_pkg::ST_READ_WAIT: begin
        cmd.res_we     = 1'b1;
        cmd.res_status = fce_pkg::STS_OK;
        cmd.res_sel    = fce_pkg::SEL_READ;
        state_next     = fce_pkg::ST_DONE;
      end
      fce_pkg::ST_WALK_CHK: begin
        if (sts.hops_zero || sts.cur_eoc || sts.cur_ge_n) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = fce_pkg::SEL_CUR;
          if (sts.hops_zero) cmd.res_status = fce_pkg::STS_OK;
          else if (sts.cur_eoc) cmd.res_status = fce_pkg::STS_CHAIN_END;
          else cmd.res_status = fce_pkg::STS_RANGE;
          state_next = fce_pkg::ST_DONE;
        end else begin
          cmd.mem_op = fce_pkg::MEM_RD_CUR;
          state_next = fce_pkg::ST_WALK_WAIT;
        end
      end
      fce_pkg::ST_WALK_WAIT: begin
        cmd.advance = 1'b1;
        state_next  = fce_pkg::ST_WALK_CHK;
      end
      fce_pkg::ST_FREE_CHK: begin
        if (sts.cur_eoc || sts.cur_ge_n || sts.iter_eq_n) begin
          cmd.res_we  = 1'b1;
          cmd.res_sel = fce_pkg::SEL_CUR;
          if (sts.cur_eoc) cmd.res_status = fce_pkg::STS_OK;
          else if (sts.cur_ge_n) cmd.res_status = fce_pkg::STS_RANGE;
          else cmd.res_status = fce_pkg::STS_CHAIN_END;
          state_next = fce_pkg::ST_DONE;
        end else begin
          cmd.mem_op = fce_pkg::MEM_RD_CUR;
          state_next = fce_pkg::ST_FREE_WAIT;
        end
      end
      fce_pkg::ST_FREE_WAIT: begin
        cmd.mem_op  = fce_pkg::MEM_WR_ZERO;
        cmd.advance = 1'b1;
        state_next  = fce_pkg::ST_FREE_CHK;
      end
      fce_pkg::ST_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.op == fce_pkg::REQ_APPEND && sts.scan_hit) begin
          cmd.found_ld = 1'b1;
          state_next   = fce_pkg::ST_APPEND_TAIL;
        end else if (sts.scan_done) begin
          cmd.res_we = 1'b1;
          if (sts.op == fce_pkg::REQ_APPEND) begin
            cmd.res_status = fce_pkg::STS_NO_FREE;
            cmd.res_sel    = fce_pkg::SEL_EOC;
          end else begin
            cmd.res_status = fce_pkg::STS_OK;
            cmd.res_sel    = fce_pkg::SEL_COUNT;
          end
          state_next = fce_pkg::ST_DONE;
        end
      end
      fce_pkg::ST_APPEND_TAIL: begin
        if (!sts.cur_eoc) cmd.mem_op = fce_pkg::MEM_WR_TAIL;
        state_next = fce_pkg::ST_APPEND_NEW;
      end
      fce_pkg::ST_APPEND_NEW: begin
        cmd.mem_op     = fce_pkg::MEM_WR_EOC;
        cmd.res_we     = 1'b1;
        cmd.res_status = fce_pkg::STS_OK;
        cmd.res_sel    = fce_pkg::SEL_FOUND;
        state_next     = fce_pkg::ST_DONE;
      end
      fce_pkg::ST_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = fce_pkg::ST_IDLE;
        end
      end
      default: state_next = fce_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
    else out_valid_next = out_valid;
  end

endmodule

// ===== sv/fat_chain_engine_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_chain_engine_core
// file allocation table chain manager: load, read, walk, free, append, count
// ----------------------------------------------------------------------------
// One request is worked at a time through a table memory with one write
// port and a registered read port. Load, unused codes and an out-of-range
// load, read or append write their result at decode; an in-range read waits
// for the registered read. A walk and a free take one read and one
// turnaround per link followed or cleared; a count streams entries 0 to n-1
// one per cycle (n = active limit), and an append streams from entry 1 until
// it takes a free entry or reaches n without finding one. The finished word
// is loaded into the response only once the previous response has left.
// A new request is taken while the previous response still waits on the
// response channel. The table has no reset and must be loaded before use.
// ----------------------------------------------------------------------------
module fat_chain_engine_core #(
  parameter int TABLE_ENTRIES = fce_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // data block count register
  input  logic                          cfg_wr_en,
  input  logic [fce_pkg::CFG_BITS-1:0]  cfg_wr_data,
  // request and response words
  fce_req_if.sink                       req,
  fce_rsp_if.source                     rsp
);

  fce_pkg::dp_cmd_t cmd;
  fce_pkg::dp_sts_t sts;

  // sequencer: owns the handshakes and the output valid flag
  fce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: table, working registers, result and output registers
  fce_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_req_type      (req.req_type),
    .in_block_index   (req.block_index),
    .in_entry_value   (req.entry_value),
    .in_hop_count     (req.hop_count),
    .cmd              (cmd),
    .sts              (sts),
    .out_status       (rsp.status),
    .out_result_index (rsp.result_index),
    .out_read_value   (rsp.read_value),
    .out_free_count   (rsp.free_count)
  );

endmodule
